// ===== design/tcw_pkg.sv =====
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = 16;
	localparam int FUNC_W = 2;

	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam int                TAB_STEP   = 4;

	localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

	typedef struct packed {
		logic              step;
		logic              home;
		logic [CHAR_W-1:0] char_code;
	} cur_cmd_t;

	typedef struct packed {
		logic              store;
		logic              scroll;
		logic [ADDR_W-1:0] cell_index;
	} cur_stat_t;

endpackage

// ===== design/tcw_cell_ram.sv =====
module tcw_cell_ram
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/tcw_cursor.sv =====
module tcw_cursor
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cur_cmd_t          cmd,
	output cur_stat_t         stat,
	output logic [COL_W-1:0]  column,
	output logic [ROW_W-1:0]  row,
	output logic [ADDR_W-1:0] position
);

	localparam logic [COL_W:0] TAB_MASK = ~((COL_W+1)'(TAB_STEP - 1));

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] pos_q;

	logic [COL_W:0]    col_t;
	logic [ROW_W:0]    row_t;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic [ADDR_W-1:0] pos_n;
	logic              printable;
	logic              scroll;

	assign printable = (cmd.char_code >= CH_PRINT_LO) && (cmd.char_code <= CH_PRINT_HI);

	always_comb begin
		col_t = {1'b0, col_q};
		row_t = {1'b0, row_q};
		case (cmd.char_code)
			CH_BS: begin
				if (col_q == '0 && row_q != '0) begin
					col_t = (COL_W+1)'(COLUMNS - 1);
					row_t = row_t - 1'b1;
				end else if (col_q != '0) begin
					col_t = col_t - 1'b1;
				end
			end
			CH_TAB: begin
				col_t = (col_t + (COL_W+1)'(TAB_STEP)) & TAB_MASK;
			end
			CH_CR: begin
				col_t = '0;
			end
			CH_LF: begin
				col_t = '0;
				row_t = row_t + 1'b1;
			end
			default: begin
				if (printable) begin
					col_t = col_t + 1'b1;
				end
			end
		endcase
		// wrap at the right edge
		if (col_t >= (COL_W+1)'(COLUMNS)) begin
			col_t = '0;
			row_t = row_t + 1'b1;
		end
		// past the bottom row: hold the cursor on the last row
		scroll = (row_t >= (ROW_W+1)'(ROWS));
		if (scroll) begin
			row_t = (ROW_W+1)'(ROWS - 1);
		end
		col_n = col_t[COL_W-1:0];
		row_n = row_t[ROW_W-1:0];
		pos_n = ADDR_W'(ADDR_W'(row_n) * ADDR_W'(COLUMNS)) + ADDR_W'(col_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pos_q <= '0;
		end else if (cmd.home) begin
			col_q <= '0;
			row_q <= '0;
			pos_q <= '0;
		end else if (cmd.step) begin
			col_q <= col_n;
			row_q <= row_n;
			pos_q <= pos_n;
		end
	end

	assign stat.store      = printable;
	assign stat.scroll     = scroll;
	assign stat.cell_index = pos_q;

	assign column   = col_q;
	assign row      = row_q;
	assign position = pos_q;

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)))
		else $error("cursor outside the grid");

	a_position_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q))
		else $error("linear cursor position out of step with column and row");

endmodule

// ===== design/text_console_writer.sv =====
// Non-scrolling writes and unused codes raise done in the next cycle; reads pass
// S_READ, clears S_CLEAR, scrolling writes S_COPY (one cell moved per cycle) then
// S_FILL. Throughput: one transfer per cycle for plain writes; the cell store (one
// write, one read port) sets the cost of reads, clears and scrolls, busy held high
// meanwhile. Reset: cursor homed, attribute 7, then all cells cleared, busy high.
// Results are strobed on done for one cycle; the receiver cannot stall.
module text_console_writer
	import tcw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               start,
	output logic               busy,
	input  logic [FUNC_W-1:0]  func,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [ADDR_W-1:0]  read_address,

	output logic               done,
	output logic [COL_W-1:0]   cursor_column,
	output logic [ROW_W-1:0]   cursor_row,
	output logic [ADDR_W-1:0]  cursor_position,
	output logic [CELL_W-1:0]  read_data,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_CLEAR,
		S_COPY,
		S_FILL
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              pend_s1;
	logic [ADDR_W-1:0] pend_addr_s1;
	logic              read_ok_q;
	logic              done_q;
	logic [CELL_W-1:0] read_data_q;
	logic [ATTR_W-1:0] attr_q;

	logic              accept;
	logic              addr_ok;
	logic              last_cell;
	logic [ADDR_W-1:0] ptr_inc;

	cur_cmd_t          cur_cmd;
	cur_stat_t         cur_stat;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign addr_ok   = (read_address < ADDR_W'(CELL_COUNT));
	assign last_cell = (ptr_q == ADDR_W'(CELL_COUNT - 1));
	assign ptr_inc   = ptr_q + 1'b1;

	// Configuration port: APB with pready tied high, one attribute register.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1] == REG_TEXT_ATTRIBUTE) begin
			attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_TEXT_ATTRIBUTE) begin
			prdata = APB_W'(attr_q);
		end
	end

	// Cursor moves on the accepting edge of a byte write; a clear homes it.
	assign cur_cmd.step      = accept && (func == FUNC_WRITE);
	assign cur_cmd.home      = accept && (func == FUNC_CLEAR);
	assign cur_cmd.char_code = char_code;

	tcw_cursor u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cur_cmd),
		.stat     (cur_stat),
		.column   (cursor_column),
		.row      (cursor_row),
		.position (cursor_position)
	);

	// Cell store port steering. During a scroll the store reads one cell a
	// row below and writes the previous read one row up; the write always
	// targets a lower cell than the read, so needs no forwarding. The last
	// moved cell is written in the first fill cycle, which holds the fill.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = read_address;
		case (state_q)
			S_IDLE: begin
				if (accept && func == FUNC_WRITE && cur_stat.store) begin
					ram_we    = 1'b1;
					ram_waddr = cur_stat.cell_index;
					ram_wdata = {attr_q, char_code};
				end
				if (accept && func == FUNC_READ && addr_ok) begin
					ram_re = 1'b1;
				end
			end
			S_INIT, S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_COPY: begin
				ram_re    = 1'b1;
				ram_raddr = ptr_q;
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = pend_addr_s1;
					ram_wdata = ram_rdata;
				end
			end
			S_FILL: begin
				ram_we = 1'b1;
				if (pend_s1) begin
					ram_waddr = pend_addr_s1;
					ram_wdata = ram_rdata;
				end else begin
					ram_wdata = BLANK_CELL;
				end
			end
			default: begin
			end
		endcase
	end

	tcw_cell_ram u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: state, sweep pointer and the result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			ptr_q        <= '0;
			pend_s1      <= 1'b0;
			pend_addr_s1 <= '0;
			read_ok_q    <= 1'b0;
			done_q       <= 1'b0;
			read_data_q  <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					// clearing pass after reset; no result
					done_q <= 1'b0;
					if (last_cell) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_inc;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_WRITE: begin
								if (cur_stat.scroll) begin
									done_q  <= 1'b0;
									ptr_q   <= ADDR_W'(COLUMNS);
									state_q <= S_COPY;
								end else begin
									done_q      <= 1'b1;
									read_data_q <= '0;
								end
							end
							FUNC_CLEAR: begin
								done_q  <= 1'b0;
								ptr_q   <= '0;
								state_q <= S_CLEAR;
							end
							FUNC_READ: begin
								done_q    <= 1'b0;
								read_ok_q <= addr_ok;
								state_q   <= S_READ;
							end
							default: begin
								done_q      <= 1'b1;
								read_data_q <= '0;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				S_READ: begin
					done_q      <= 1'b1;
					read_data_q <= read_ok_q ? ram_rdata : '0;
					state_q     <= S_IDLE;
				end
				S_CLEAR: begin
					if (last_cell) begin
						ptr_q       <= '0;
						done_q      <= 1'b1;
						read_data_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						ptr_q  <= ptr_inc;
						done_q <= 1'b0;
					end
				end
				S_COPY: begin
					done_q       <= 1'b0;
					pend_s1      <= 1'b1;
					pend_addr_s1 <= ptr_q - ADDR_W'(COLUMNS);
					if (last_cell) begin
						ptr_q   <= ADDR_W'(CELL_COUNT - COLUMNS);
						state_q <= S_FILL;
					end else begin
						ptr_q <= ptr_inc;
					end
				end
				S_FILL: begin
					if (pend_s1) begin
						pend_s1 <= 1'b0;
						done_q  <= 1'b0;
					end else if (last_cell) begin
						ptr_q       <= '0;
						done_q      <= 1'b1;
						read_data_q <= '0;
						state_q     <= S_IDLE;
					end else begin
						ptr_q  <= ptr_inc;
						done_q <= 1'b0;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobed while an operation is still running");

	a_pend_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_COPY || state_q == S_FILL))
		else $error("moved cell pending outside a scroll");

	a_pend_above_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> pend_addr_s1 < ADDR_W'(CELL_COUNT - COLUMNS))
		else $error("scroll move targets the bottom row");

	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == FUNC_READ |=> state_q == S_READ && $past(addr_ok) == read_ok_q)
		else $error("read transfer not followed by the read cycle");

endmodule
